### hdl/wheel_speed_bangbang_pi_core_assert.svh
// assertion macros for the wheel speed controller
`ifndef WHEEL_SPEED_BANGBANG_PI_CORE_ASSERT_SVH
`define WHEEL_SPEED_BANGBANG_PI_CORE_ASSERT_SVH

// condition and consequence in the same cycle
`define WSBP_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// consequence in the cycle after the condition
`define WSBP_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### hdl/wsbp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package wsbp_pkg;

   typedef logic signed [15:0] speed_type;
   typedef logic signed [16:0] err_type;
   typedef logic signed [17:0] derr_type;
   typedef logic signed [15:0] drive_type;
   typedef logic signed [21:0] acc_type;
   typedef logic signed [29:0] prod_type;
   typedef logic signed [26:0] band_type;
   typedef logic signed [32:0] kie_type;
   typedef logic signed [35:0] pi_type;

   typedef enum logic [1:0] {
      CSR_PROP_GAIN   = 2'd0,
      CSR_INTEG_GAIN  = 2'd1,
      CSR_MOTOR_RANGE = 2'd2
   } csr_index_type;

   localparam logic [14:0] MOTOR_RANGE_RESET = 15'd8000;

   // error thresholds, Q8.8
   localparam err_type  E_BANG_ON    = 17'sd256;
   localparam err_type  E_BANG_FORCE = 17'sd384;
   localparam err_type  E_SETTLE     = 17'sd38;
   localparam derr_type DE_LIMIT     = 18'sd25;

   localparam logic [7:0] STOP_LIMIT = 8'd30;

   // band factors 1.1 and 0.8 over 256
   localparam band_type BAND_HI = 27'sd282;
   localparam band_type BAND_LO = 27'sd205;

   // bang-bang drive factors over 256
   localparam prod_type K_FAST   = 30'sd5000;
   localparam prod_type K_REV    = -30'sd3000;
   localparam prod_type K_CRUISE = 30'sd2500;

   localparam logic [2:0] BAND_MAX  = 3'd7;
   localparam logic [2:0] BAND_EXIT = 3'd5;

endpackage

`default_nettype wire

### hdl/wheel_speed_bangbang_pi_core.sv
`timescale 1ns / 1ps
`default_nettype none

// Two-wheel speed controller, one control tick per request. A request is taken into an
// input register, where the speed error, band compares, bang-bang drive levels and the
// integral product are formed; in the next stage the per-wheel state (brake hold,
// accelerate and decelerate phases, PI accumulator) is updated and the saturated drives are
// loaded into the response register. A response passes the input and response registers,
// and one request is taken every cycle while the response side keeps up; the rate is set by
// the per-wheel state update in the second stage. Registers may be written at any time the
// block is idle: 0 proportional gain, 1 integral gain, 2 motor range (reset 8000).
module wheel_speed_bangbang_pi_core
   import wsbp_pkg::*;
#(
   parameter int HOLD_TICKS     = 255,
   parameter int INTEGRAL_DELAY = 10
) (
   input  wire logic               clock,
   input  wire logic               reset,

   input  wire logic               csr_valid,
   output logic                    csr_ready,
   input  wire logic [1:0]         csr_index,
   input  wire logic [15:0]        csr_data,

   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic signed [15:0] req_target_left,
   input  wire logic signed [15:0] req_target_right,
   input  wire logic signed [15:0] req_speed_left,
   input  wire logic signed [15:0] req_speed_right,
   input  wire logic signed [15:0] req_goal_speed,
   input  wire logic               req_goal_changed,
   input  wire logic [7:0]         req_stop_mark_count,

   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic signed [15:0]      rsp_drive_left,
   output logic signed [15:0]      rsp_drive_right
);

   localparam int HC_W = $clog2(HOLD_TICKS + 1);
   localparam int SF_W = $clog2(INTEGRAL_DELAY + 1);

   // configuration
   logic [15:0] prop_gain_ff;
   logic [15:0] integ_gain_ff;
   logic [14:0] motor_range_ff;

   // input stage
   logic       s1_valid_ff;
   logic       goal_changed_ff, goal_zero_ff, stop_hit_ff;
   err_type    e_ff        [2];
   err_type    e_in        [2];
   kie_type    kie_ff      [2];
   kie_type    kie_in      [2];
   acc_type    bang_acc_ff [2];
   acc_type    bang_acc_in [2];
   acc_type    bang_dec_ff [2];
   acc_type    bang_dec_in [2];
   acc_type    cruise_ff   [2];
   acc_type    cruise_in   [2];
   logic [1:0] spd_lt_tgt_ff, spd_lt_tgt_in;
   logic [1:0] spd_gt_tgt_ff, spd_gt_tgt_in;
   logic [1:0] band_hi_ff, band_hi_in;
   logic [1:0] band_lo_ff, band_lo_in;
   logic [1:0] spd_gt_goal_ff, spd_gt_goal_in;

   // wheel state
   logic [1:0]      brake_hold_ff, brake_hold_in;
   logic [HC_W-1:0] hold_count_ff    [2];
   logic [HC_W-1:0] hold_count_in    [2];
   logic [1:0]      accel_phase_ff, accel_phase_in;
   logic [1:0]      decel_phase_ff, decel_phase_in;
   logic [2:0]      band_count_ff    [2];
   logic [2:0]      band_count_in    [2];
   logic [1:0]      bang_request_ff, bang_request_in;
   logic [1:0]      settle_started_ff, settle_started_in;
   logic [SF_W-1:0] settle_frames_ff [2];
   logic [SF_W-1:0] settle_frames_in [2];
   err_type         last_error_ff    [2];
   drive_type       drive_accum_ff   [2];
   drive_type       drive_accum_in   [2];

   // response stage
   logic      rsp_valid_ff, rsp_valid_in;
   drive_type drive_left_ff, drive_right_ff;

   logic      out_load;
   speed_type tgt [2];
   speed_type spd [2];
   acc_type   range_acc;
   err_type   range_ext;
   err_type   drive_left_ext, drive_right_ext;

   assign csr_ready = 1'b1;
   assign out_load  = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !s1_valid_ff || out_load;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_drive_left  = drive_left_ff;
   assign rsp_drive_right = drive_right_ff;

   assign tgt[0] = req_target_left;
   assign tgt[1] = req_target_right;
   assign spd[0] = req_speed_left;
   assign spd[1] = req_speed_right;

   assign range_acc = signed'(22'(motor_range_ff));
   assign range_ext = signed'(17'(motor_range_ff));
   assign drive_left_ext  = 17'(drive_left_ff);
   assign drive_right_ext = 17'(drive_right_ff);

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         prop_gain_ff   <= '0;
         integ_gain_ff  <= '0;
         motor_range_ff <= MOTOR_RANGE_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_PROP_GAIN:   prop_gain_ff   <= csr_data;
            CSR_INTEG_GAIN:  integ_gain_ff  <= csr_data;
            CSR_MOTOR_RANGE: motor_range_ff <= csr_data[14:0];
            default: ;
         endcase
      end
   end

   // per-wheel terms that depend on the request and the integral gain
   always_comb begin
      for (int w = 0; w < 2; w++) begin
         prod_type tgt_p;
         prod_type p_fast;
         prod_type p_rev;
         prod_type p_cruise;
         band_type spd_b;
         logic     pos;
         tgt_p    = 30'(tgt[w]);
         p_fast   = tgt_p * K_FAST;
         p_rev    = tgt_p * K_REV;
         p_cruise = tgt_p * K_CRUISE;
         pos      = tgt[w] > 16'sd0;
         spd_b    = 27'($signed({spd[w], 8'h00}));
         e_in[w]        = 17'(tgt[w]) - 17'(spd[w]);
         kie_in[w]      = 33'($signed({1'b0, integ_gain_ff})) * 33'(e_in[w]);
         bang_acc_in[w] = pos ? acc_type'(p_fast[29:8]) : acc_type'(p_rev[29:8]);
         bang_dec_in[w] = pos ? acc_type'(p_rev[29:8]) : acc_type'(p_fast[29:8]);
         cruise_in[w]   = acc_type'(p_cruise[29:8]);
         spd_lt_tgt_in[w]  = spd[w] < tgt[w];
         spd_gt_tgt_in[w]  = spd[w] > tgt[w];
         band_hi_in[w]     = spd_b < 27'(tgt[w]) * BAND_HI;
         band_lo_in[w]     = spd_b > 27'(tgt[w]) * BAND_LO;
         spd_gt_goal_in[w] = spd[w] > req_goal_speed;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_ready) begin
         s1_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         goal_changed_ff <= req_goal_changed;
         goal_zero_ff    <= req_goal_speed == 16'sd0;
         stop_hit_ff     <= req_stop_mark_count > STOP_LIMIT;
         e_ff            <= e_in;
         kie_ff          <= kie_in;
         bang_acc_ff     <= bang_acc_in;
         bang_dec_ff     <= bang_dec_in;
         cruise_ff       <= cruise_in;
         spd_lt_tgt_ff   <= spd_lt_tgt_in;
         spd_gt_tgt_ff   <= spd_gt_tgt_in;
         band_hi_ff      <= band_hi_in;
         band_lo_ff      <= band_lo_in;
         spd_gt_goal_ff  <= spd_gt_goal_in;
      end
   end

   // state update and drive for each wheel
   always_comb begin
      for (int w = 0; w < 2; w++) begin
         logic            bh, br, ap, dp, ss, ki_on;
         logic [HC_W-1:0] hc;
         logic [2:0]      bc;
         logic [SF_W-1:0] sf;
         acc_type         acc;
         derr_type        de;
         logic [15:0]     kp;
         pi_type          pi_sum;
         err_type         e;
         bh    = brake_hold_ff[w] | (goal_changed_ff & goal_zero_ff);
         br    = bang_request_ff[w] | (goal_changed_ff & !goal_zero_ff);
         ap    = accel_phase_ff[w];
         dp    = decel_phase_ff[w];
         ss    = settle_started_ff[w];
         hc    = hold_count_ff[w];
         bc    = band_count_ff[w];
         sf    = settle_frames_ff[w];
         e     = e_ff[w];
         acc   = 22'(drive_accum_ff[w]);
         ki_on = 1'b1;
         de    = 18'(e) - 18'(last_error_ff[w]);
         kp    = (de > DE_LIMIT || de < -DE_LIMIT) ? '0 : prop_gain_ff;
         pi_sum = '0;

         if (e > E_BANG_ON) begin
            if (e > E_BANG_FORCE || br) begin
               ap = 1'b1;
               br = 1'b0;
            end
            bc = '0;
            ss = 1'b0;
            sf = '0;
         end
         if (e < -E_BANG_ON) begin
            if (e < -E_BANG_FORCE || br) begin
               dp = 1'b1;
               br = 1'b0;
            end
            bc = '0;
            ss = 1'b0;
            sf = '0;
         end

         priority if (bh) begin
            if (spd_gt_goal_ff[w] || stop_hit_ff) begin
               acc = -range_acc;
            end else begin
               hc = hc + 1'b1;
               if (hc >= HC_W'(HOLD_TICKS)) begin
                  bh = 1'b0;
                  hc = '0;
               end
               acc = '0;
            end
         end else if (ap) begin
            priority if (spd_lt_tgt_ff[w]) begin
               acc = bang_acc_ff[w];
            end else if (band_hi_ff[w]) begin
               if (bc < BAND_MAX) bc = bc + 1'b1;
               if (bc > BAND_EXIT) begin
                  ap  = 1'b0;
                  acc = cruise_ff[w];
               end
            end else begin
               ap  = 1'b0;
               acc = cruise_ff[w];
            end
         end else if (dp) begin
            priority if (spd_gt_tgt_ff[w]) begin
               acc = bang_dec_ff[w];
            end else if (band_lo_ff[w]) begin
               if (bc < BAND_MAX) bc = bc + 1'b1;
               if (bc > BAND_EXIT) begin
                  dp  = 1'b0;
                  acc = cruise_ff[w];
               end
            end else begin
               dp  = 1'b0;
               acc = cruise_ff[w];
            end
         end else begin
            if (e <= E_SETTLE && e >= -E_SETTLE && !ss) begin
               ss = 1'b1;
               sf = '0;
            end
            if (ss) begin
               if (sf < SF_W'(INTEGRAL_DELAY)) begin
                  ki_on = 1'b0;
                  sf    = sf + 1'b1;
               end
            end else begin
               sf = SF_W'(INTEGRAL_DELAY);
            end
            pi_sum = 36'($signed({1'b0, kp})) * 36'(de)
                     + (ki_on ? 36'(kie_ff[w]) : '0);
            acc = acc + 22'($signed(pi_sum[35:16]));
         end

         if (acc > range_acc) acc = range_acc;
         if (acc < -range_acc) acc = -range_acc;

         brake_hold_in[w]     = bh;
         hold_count_in[w]     = hc;
         accel_phase_in[w]    = ap;
         decel_phase_in[w]    = dp;
         band_count_in[w]     = bc;
         bang_request_in[w]   = br;
         settle_started_in[w] = ss;
         settle_frames_in[w]  = sf;
         drive_accum_in[w]    = acc[15:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         brake_hold_ff     <= '0;
         accel_phase_ff    <= '0;
         decel_phase_ff    <= '0;
         bang_request_ff   <= '0;
         settle_started_ff <= '0;
         for (int w = 0; w < 2; w++) begin
            hold_count_ff[w]    <= '0;
            band_count_ff[w]    <= '0;
            settle_frames_ff[w] <= '0;
            last_error_ff[w]    <= '0;
            drive_accum_ff[w]   <= '0;
         end
      end else if (out_load) begin
         brake_hold_ff     <= brake_hold_in;
         accel_phase_ff    <= accel_phase_in;
         decel_phase_ff    <= decel_phase_in;
         bang_request_ff   <= bang_request_in;
         settle_started_ff <= settle_started_in;
         hold_count_ff     <= hold_count_in;
         band_count_ff     <= band_count_in;
         settle_frames_ff  <= settle_frames_in;
         last_error_ff     <= e_ff;
         drive_accum_ff    <= drive_accum_in;
      end
   end

   // response register
   always_comb begin
      priority if (out_load) rsp_valid_in = 1'b1;
      else if (rsp_ready)    rsp_valid_in = 1'b0;
      else                   rsp_valid_in = rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         drive_left_ff  <= drive_accum_in[0];
         drive_right_ff <= drive_accum_in[1];
      end
   end

`include "wheel_speed_bangbang_pi_core_assert.svh"

   `WSBP_ASSERT_NEXT(a_left_in_range, out_load, drive_left_ext <= $past(range_ext) && drive_left_ext >= -$past(range_ext), "left drive outside motor range")
   `WSBP_ASSERT_NEXT(a_right_in_range, out_load, drive_right_ext <= $past(range_ext) && drive_right_ext >= -$past(range_ext), "right drive outside motor range")
   `WSBP_ASSERT_NOW(a_left_hold_count, hold_count_ff[0] != '0, brake_hold_ff[0], "left hold count running without hold")
   `WSBP_ASSERT_NOW(a_right_hold_count, hold_count_ff[1] != '0, brake_hold_ff[1], "right hold count running without hold")
   `WSBP_ASSERT_NOW(a_settle_limit, 1'b1, settle_frames_ff[0] <= SF_W'(INTEGRAL_DELAY) && settle_frames_ff[1] <= SF_W'(INTEGRAL_DELAY), "settle count past integral delay")

endmodule

`default_nettype wire

### tb/tb_wheel_speed_bangbang_pi_core.sv
`timescale 1ns / 1ps

module tb_wheel_speed_bangbang_pi_core
   import wsbp_pkg::*;
();

   localparam int HOLD_TICKS     = 255;
   localparam int INTEGRAL_DELAY = 10;
   localparam int IDLE_LIMIT     = 2000;
   localparam int STOP_MARKS_MAX = 30;
   localparam longint ACCEL_K    = 5000;
   localparam longint REVERSE_K  = -3000;
   localparam longint CRUISE_K   = 2500;
   localparam longint BAND_HIGH  = 282;
   localparam longint BAND_LOW   = 205;
   localparam longint ERR_BANG   = 256;
   localparam longint ERR_FORCE  = 384;
   localparam longint ERR_SETTLE = 38;
   localparam longint DERR_MAX   = 25;

   typedef struct {
      speed_type  target_left;
      speed_type  target_right;
      speed_type  speed_left;
      speed_type  speed_right;
      speed_type  goal_speed;
      logic       goal_changed;
      logic [7:0] stop_marks;
   } control_tick_type;

   typedef struct {
      drive_type left;
      drive_type right;
   } drive_pair_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              csr_valid = 1'b0;
   logic              csr_ready;
   csr_index_type     csr_index = CSR_PROP_GAIN;
   logic [15:0]       csr_data = '0;
   logic              req_valid = 1'b0;
   logic              req_ready;
   speed_type         req_target_left = '0;
   speed_type         req_target_right = '0;
   speed_type         req_speed_left = '0;
   speed_type         req_speed_right = '0;
   speed_type         req_goal_speed = '0;
   logic              req_goal_changed = 1'b0;
   logic [7:0]        req_stop_mark_count = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b1;
   drive_type         rsp_drive_left;
   drive_type         rsp_drive_right;

   // controller copy: configuration and per-wheel state
   logic [15:0] kp_cfg = '0;
   logic [15:0] ki_cfg = '0;
   logic [14:0] range_cfg = 15'd8000;
   bit          brake_hold_q[2] = '{0, 0};
   bit [7:0]    hold_cnt_q[2] = '{0, 0};
   bit          accel_q[2] = '{0, 0};
   bit          decel_q[2] = '{0, 0};
   bit [2:0]    band_cnt_q[2] = '{0, 0};
   bit          bang_req_q[2] = '{0, 0};
   bit          settled_q[2] = '{0, 0};
   bit [3:0]    settle_cnt_q[2] = '{0, 0};
   longint      last_err_q[2] = '{0, 0};
   longint      drive_acc_q[2] = '{0, 0};

   drive_pair_type drives_due[$];
   int          error_count = 0;
   int          quiet_cycles = 0;
   int          rsp_stall_left = 0;
   bit          req_idle_on = 1'b1;
   bit          rsp_idle_on = 1'b1;

   wheel_speed_bangbang_pi_core #(
      .HOLD_TICKS     (HOLD_TICKS),
      .INTEGRAL_DELAY (INTEGRAL_DELAY)
   ) dut (
      .clock               (clock),
      .reset               (reset),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_index           (csr_index),
      .csr_data            (csr_data),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_target_left     (req_target_left),
      .req_target_right    (req_target_right),
      .req_speed_left      (req_speed_left),
      .req_speed_right     (req_speed_right),
      .req_goal_speed      (req_goal_speed),
      .req_goal_changed    (req_goal_changed),
      .req_stop_mark_count (req_stop_mark_count),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_drive_left      (rsp_drive_left),
      .rsp_drive_right     (rsp_drive_right)
   );

   always #1 clock = ~clock;

   function automatic speed_type clip_speed(input longint v);
      if (v > 32767) return 16'sh7fff;
      if (v < -32768) return 16'sh8000;
      return speed_type'(v);
   endfunction

   function automatic longint srand(input int mag);
      return longint'($urandom_range(0, 2 * mag)) - mag;
   endfunction

   function automatic longint pick_speed();
      case ($urandom_range(0, 7))
         0: return longint'(speed_type'($urandom));
         1: return ($urandom_range(0, 1) != 0) ? 32767 : -32768;
         default: return srand(6000);
      endcase
   endfunction

   function automatic void count_band(input int w);
      if (band_cnt_q[w] < 3'd7) band_cnt_q[w] = band_cnt_q[w] + 3'd1;
   endfunction

   function automatic longint wheel_drive(input int w, input longint tgt, input longint spd,
                                          input longint goal, input int stop);
      longint e, acc, rng, de, kp, ki;
      e   = tgt - spd;
      acc = drive_acc_q[w];
      rng = longint'(range_cfg);
      if (e > ERR_BANG) begin
         if (e > ERR_FORCE || bang_req_q[w]) begin
            accel_q[w] = 1'b1;
            bang_req_q[w] = 1'b0;
         end
         band_cnt_q[w] = '0;
         settled_q[w] = 1'b0;
         settle_cnt_q[w] = '0;
      end
      if (e < -ERR_BANG) begin
         if (e < -ERR_FORCE || bang_req_q[w]) begin
            decel_q[w] = 1'b1;
            bang_req_q[w] = 1'b0;
         end
         band_cnt_q[w] = '0;
         settled_q[w] = 1'b0;
         settle_cnt_q[w] = '0;
      end

      if (brake_hold_q[w]) begin
         if (spd > goal || stop > STOP_MARKS_MAX) begin
            acc = -rng;
         end else begin
            hold_cnt_q[w] = hold_cnt_q[w] + 8'd1;
            if (hold_cnt_q[w] >= HOLD_TICKS) begin
               brake_hold_q[w] = 1'b0;
               hold_cnt_q[w] = '0;
            end
            acc = 0;
         end
      end else if (accel_q[w]) begin
         if (spd < tgt) begin
            acc = (tgt * ((tgt > 0) ? ACCEL_K : REVERSE_K)) >>> 8;
         end else if (spd * 256 < tgt * BAND_HIGH) begin
            count_band(w);
            if (band_cnt_q[w] > 3'd5) begin
               accel_q[w] = 1'b0;
               acc = (tgt * CRUISE_K) >>> 8;
            end
         end else begin
            accel_q[w] = 1'b0;
            acc = (tgt * CRUISE_K) >>> 8;
         end
      end else if (decel_q[w]) begin
         if (spd > tgt) begin
            acc = (tgt * ((tgt > 0) ? REVERSE_K : ACCEL_K)) >>> 8;
         end else if (spd * 256 > tgt * BAND_LOW) begin
            count_band(w);
            if (band_cnt_q[w] > 3'd5) begin
               decel_q[w] = 1'b0;
               acc = (tgt * CRUISE_K) >>> 8;
            end
         end else begin
            decel_q[w] = 1'b0;
            acc = (tgt * CRUISE_K) >>> 8;
         end
      end else begin
         de = e - last_err_q[w];
         kp = (de > DERR_MAX || de < -DERR_MAX) ? 0 : longint'(kp_cfg);
         ki = longint'(ki_cfg);
         if (e <= ERR_SETTLE && e >= -ERR_SETTLE && !settled_q[w]) begin
            settled_q[w] = 1'b1;
            settle_cnt_q[w] = '0;
         end
         if (settled_q[w]) begin
            if (settle_cnt_q[w] < INTEGRAL_DELAY) begin
               ki = 0;
               settle_cnt_q[w] = settle_cnt_q[w] + 4'd1;
            end
         end else begin
            settle_cnt_q[w] = 4'(INTEGRAL_DELAY);
         end
         acc = acc + ((kp * de + ki * e) >>> 16);
      end

      last_err_q[w] = e;
      if (acc > rng) acc = rng;
      if (acc < -rng) acc = -rng;
      drive_acc_q[w] = acc;
      return acc;
   endfunction

   function automatic void predict_drives(input control_tick_type t);
      drive_pair_type d;
      if (t.goal_changed) begin
         if (t.goal_speed == 0) begin
            brake_hold_q[0] = 1'b1;
            brake_hold_q[1] = 1'b1;
         end else begin
            bang_req_q[0] = 1'b1;
            bang_req_q[1] = 1'b1;
         end
      end
      d.left  = drive_type'(wheel_drive(0, t.target_left, t.speed_left, t.goal_speed,
                                        t.stop_marks));
      d.right = drive_type'(wheel_drive(1, t.target_right, t.speed_right, t.goal_speed,
                                        t.stop_marks));
      drives_due.push_back(d);
   endfunction

   task automatic log_error(input string msg);
      error_count++;
      if (error_count <= 10) $display("%0t: %s", $realtime, msg);
   endtask

   task automatic send_tick(input control_tick_type t);
      int gap;
      if (req_idle_on && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 6);
         repeat (gap) begin
            @(negedge clock);
            req_valid <= 1'b0;
         end
      end
      @(negedge clock);
      req_valid           <= 1'b1;
      req_target_left     <= t.target_left;
      req_target_right    <= t.target_right;
      req_speed_left      <= t.speed_left;
      req_speed_right     <= t.speed_right;
      req_goal_speed      <= t.goal_speed;
      req_goal_changed    <= t.goal_changed;
      req_stop_mark_count <= t.stop_marks;
      do @(posedge clock); while (!req_ready);
      predict_drives(t);
   endtask

   task automatic send_fields(input longint tl, input longint tr, input longint sl,
                              input longint sr, input longint goal, input bit changed,
                              input int stop);
      control_tick_type t;
      t.target_left  = clip_speed(tl);
      t.target_right = clip_speed(tr);
      t.speed_left   = clip_speed(sl);
      t.speed_right  = clip_speed(sr);
      t.goal_speed   = clip_speed(goal);
      t.goal_changed = changed;
      t.stop_marks   = 8'(stop);
      send_tick(t);
   endtask

   task automatic drain_results();
      @(negedge clock);
      req_valid <= 1'b0;
      while (drives_due.size() != 0) @(posedge clock);
   endtask

   task automatic write_reg(input csr_index_type idx, input logic [15:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_PROP_GAIN:   kp_cfg = value;
         CSR_INTEG_GAIN:  ki_cfg = value;
         CSR_MOTOR_RANGE: range_cfg = value[14:0];
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic write_gains(input logic [15:0] kp, input logic [15:0] ki,
                              input logic [15:0] rng);
      drain_results();
      write_reg(CSR_PROP_GAIN, kp);
      write_reg(CSR_INTEG_GAIN, ki);
      write_reg(CSR_MOTOR_RANGE, rng);
   endtask

   // wheels start away from target and close in on it, with measurement noise
   task automatic drive_episode(input int ticks);
      control_tick_type t;
      longint tgt[2], spd[2], goal, off;
      int noise, k, w;
      goal = pick_speed();
      if (goal == 0) goal = 256;
      case ($urandom_range(0, 2))
         0: noise = 3;
         1: noise = 12;
         default: noise = 45;
      endcase
      for (w = 0; w < 2; w++) begin
         tgt[w] = pick_speed();
         off = ($urandom_range(0, 1) != 0) ? longint'($urandom_range(257, 384))
                                            : longint'($urandom_range(385, 3000));
         spd[w] = clip_speed(($urandom_range(0, 1) != 0) ? tgt[w] - off : tgt[w] + off);
      end
      for (k = 0; k < ticks; k++) begin
         t.target_left  = clip_speed(tgt[0]);
         t.target_right = clip_speed(tgt[1]);
         t.speed_left   = clip_speed(spd[0]);
         t.speed_right  = clip_speed(spd[1]);
         t.goal_speed   = clip_speed(goal);
         t.goal_changed = (k == 0) || ($urandom_range(0, 63) == 0);
         t.stop_marks   = ($urandom_range(0, 31) == 0) ? 8'($urandom_range(31, 255))
                                                      : 8'($urandom_range(0, 30));
         send_tick(t);
         for (w = 0; w < 2; w++)
            spd[w] = clip_speed(spd[w] + (tgt[w] - spd[w]) / 4 + srand(noise));
      end
   endtask

   task automatic test_directed();
      int k;
      send_fields(32767, -32768, -32768, 32767, 32767, 0, 0);
      send_fields(-32768, 32767, 32767, -32768, -32768, 0, 255);
      repeat (7) send_fields(1000, -1000, 1050, -1050, 2000, 0, 0);
      repeat (3) send_fields(1000, -1000, 960, -990, 2000, 0, 0);
      repeat (4) send_fields(500, 500, 500, 500, 2000, 0, 0);
      send_fields(1300, -1300, 1000, -1000, 3000, 1, 0);
      send_fields(1300, -1300, 1100, -1100, 3000, 0, 0);
      // goal of zero arms the braking hold
      send_fields(200, 200, 100, 100, 0, 1, 31);
      send_fields(-100, -100, -100, -100, 0, 0, 30);
      send_fields(-100, -100, -100, -100, 0, 0, 31);
      for (k = 0; k < 2; k++) send_fields(0, 0, 0, 0, 0, 0, 0);
   endtask

   task automatic test_brake_hold();
      longint sl, sr;
      int k;
      send_fields(pick_speed(), pick_speed(), 1000, 2000, 0, 1, 200);
      repeat (4)
         send_fields(srand(2000), srand(2000), 300 + srand(200), 500, 0, 0,
                     $urandom_range(0, 255));
      for (k = 0; k < 265; k++) begin
         sl = -longint'($urandom_range(0, 3000));
         sr = -longint'($urandom_range(0, 3000));
         send_fields(sl + srand(200), sr + srand(200), sl, sr, 0,
                     $urandom_range(0, 31) == 0, $urandom_range(0, 30));
      end
      for (k = 0; k < 12; k++) begin
         sl = srand(1000);
         sr = srand(1000);
         send_fields(sl + srand(30), sr + srand(30), sl, sr, 500, 0, $urandom_range(0, 30));
      end
   endtask

   task automatic test_config_sweep();
      logic [15:0] kp_set[5], ki_set[5], rng_set[5];
      int k;
      kp_set  = '{16'd0, 16'hffff, 16'd256, 16'($urandom), 16'd3000};
      ki_set  = '{16'd0, 16'hffff, 16'd512, 16'($urandom), 16'd1500};
      rng_set = '{16'd0, 16'd32767, 16'd8000, 16'($urandom_range(0, 32767)), 16'd1200};
      for (k = 0; k < 5; k++) begin
         write_gains(kp_set[k], ki_set[k], rng_set[k]);
         req_idle_on = (k != 2);
         rsp_idle_on = (k != 3);
         drive_episode($urandom_range(25, 50));
         drive_episode($urandom_range(25, 50));
      end
      req_idle_on = 1'b1;
      rsp_idle_on = 1'b1;
   endtask

   task automatic test_bang_bang_pi();
      int k;
      write_gains(16'd2000, 16'd800, 16'd10000);
      for (k = 0; k < 10; k++) begin
         req_idle_on = ($urandom_range(0, 3) != 0);
         drive_episode($urandom_range(30, 60));
      end
      req_idle_on = 1'b1;
   endtask

   task automatic test_random_fields();
      control_tick_type t;
      int k;
      for (k = 0; k < 200; k++) begin
         t.target_left  = speed_type'($urandom);
         t.target_right = speed_type'($urandom);
         t.speed_left   = speed_type'($urandom);
         t.speed_right  = speed_type'($urandom);
         t.goal_speed   = speed_type'($urandom);
         t.goal_changed = ($urandom_range(0, 7) == 0);
         t.stop_marks   = 8'($urandom);
         // keep the wheels out of a long braking hold here
         if (t.goal_changed && t.goal_speed == 0) t.goal_speed = 16'sd1;
         send_tick(t);
      end
   endtask

   task automatic test_back_to_back();
      int k;
      drain_results();
      req_idle_on = 1'b0;
      rsp_idle_on = 1'b0;
      rsp_stall_left = 0;
      for (k = 0; k < 4; k++) drive_episode(40);
   endtask

   always @(posedge clock) begin
      drive_pair_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (drives_due.size() == 0) begin
            log_error($sformatf("unexpected response: left %0d right %0d",
                                rsp_drive_left, rsp_drive_right));
         end else begin
            want = drives_due.pop_front();
            if (rsp_drive_left !== want.left)
               log_error($sformatf("drive_left: expected %0d, got %0d",
                                   want.left, rsp_drive_left));
            if (rsp_drive_right !== want.right)
               log_error($sformatf("drive_right: expected %0d, got %0d",
                                   want.right, rsp_drive_right));
         end
      end
   end

   always @(negedge clock) begin
      if (rsp_stall_left > 0) begin
         rsp_stall_left--;
         rsp_ready <= 1'b0;
      end else if (rsp_idle_on && $urandom_range(0, 5) == 0) begin
         rsp_stall_left = $urandom_range(0, 5);
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= IDLE_LIMIT) begin
            $display("timeout: no handshake for %0d cycles, %0d responses outstanding",
                     IDLE_LIMIT, drives_due.size());
            $display("** wheel_speed_bangbang_pi_core: FAILED **");
            $finish;
         end
      end
   end

   initial begin
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed();
      test_brake_hold();
      test_config_sweep();
      test_bang_bang_pi();
      test_random_fields();
      test_back_to_back();
      drain_results();
      repeat (10) @(posedge clock);
      if (error_count == 0) begin
         $display("** wheel_speed_bangbang_pi_core: PASSED **");
      end else begin
         $display("** wheel_speed_bangbang_pi_core: FAILED **");
      end
      $finish;
   end

endmodule
